FILE: rtl/supersampled_triangle_rasterizer_assert.svh
// Assertion macros used by the rasterizer RTL.
`ifndef SUPERSAMPLED_TRIANGLE_RASTERIZER_ASSERT_SVH
`define SUPERSAMPLED_TRIANGLE_RASTERIZER_ASSERT_SVH

// Same-cycle implication.
`define SSRAST_ASSERT_IMPLY(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// Next-cycle implication.
`define SSRAST_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

FILE: rtl/ssrast_pkg.sv
package ssrast_pkg;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_STEP = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      CSR_SAMPLES_LOG2 = 2'd0,
      CSR_FRAME_WIDTH  = 2'd1,
      CSR_FRAME_HEIGHT = 2'd2
   } csr_index_type;

   localparam int COORD_W   = 16;
   localparam int COLOR_W   = 24;
   localparam int PIX_W     = 11;
   localparam int MASK_W    = 16;
   localparam int MASK_IDX_W = 4;
   localparam int CSR_W     = 12;
   localparam int REQ_DATA_W = 6 * COORD_W + COLOR_W;
   localparam int RSP_DATA_W = 64;
   localparam logic [CSR_W-1:0] FRAME_RESET = 12'd2048;

endpackage

FILE: rtl/supersampled_triangle_rasterizer.sv
// Step items taken while busy: one registered result each, one step per cycle while
// req_tready is high. Load items with a non-empty box: edge setup runs through two extra
// stages (the six setup multipliers, then the subtract into the edge values), holding
// req_tready low. Per-step cost is set by the per-sample three-operand adds on the edge
// values. Reset (reset, synchronous, active high) clears traversal and handshake control
// and sets the registers to one sample per pixel and a 2048 x 2048 frame.
`include "supersampled_triangle_rasterizer_assert.svh"

module supersampled_triangle_rasterizer #(
   parameter int COORD_FRAC_BITS = 4,
   parameter int MAX_FRAME_SIDE  = 2048,
   parameter int MAX_SAMPLES     = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // vert0_x, vert0_y, vert1_x, vert1_y, vert2_x, vert2_y, fill_color
   input  logic [ssrast_pkg::REQ_DATA_W-1:0]    req_tdata,
   // operation
   input  logic                                 req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // pixel_x, pixel_y, coverage_mask, pixel_color, zero pad
   output logic [ssrast_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // last_pixel
   output logic                                 rsp_tlast,
   input  logic                                 csr_we,
   input  logic [1:0]                           csr_index,
   input  logic [ssrast_pkg::CSR_W-1:0]         csr_wdata
);

   localparam int CW   = ssrast_pkg::COORD_W;
   localparam int MAXL = (MAX_SAMPLES >= 16) ? 2 : ((MAX_SAMPLES >= 4) ? 1 : 0);
   localparam int MAXS = 1 << MAXL;
   localparam int LK   = MAXL + 1;
   localparam int XW   = $clog2(MAX_FRAME_SIDE);
   localparam int BW   = CW + 2;
   localparam int DW   = CW + 1;
   localparam int PW   = (((XW + COORD_FRAC_BITS) > CW) ? (XW + COORD_FRAC_BITS) : CW) + 2;
   localparam int MW   = DW + PW;
   localparam int EW   = DW + PW + LK + 4;

   // configuration
   logic [1:0]                   samples_log2_ff;
   logic [ssrast_pkg::CSR_W-1:0] frame_w_ff, frame_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         samples_log2_ff <= '0;
         frame_w_ff      <= ssrast_pkg::FRAME_RESET;
         frame_h_ff      <= ssrast_pkg::FRAME_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            ssrast_pkg::CSR_SAMPLES_LOG2: samples_log2_ff <= csr_wdata[1:0];
            ssrast_pkg::CSR_FRAME_WIDTH:  frame_w_ff      <= csr_wdata;
            ssrast_pkg::CSR_FRAME_HEIGHT: frame_h_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   // triangle state
   logic signed [CW-1:0] cx_ff [3], cy_ff [3], cx_in [3], cy_in [3];
   logic signed [DW-1:0] dx_ff [3], dy_ff [3], dx_in [3], dy_in [3];
   logic signed [MW-1:0] prx_ff [3], pry_ff [3], prx_in [3], pry_in [3];
   logic signed [EW-1:0] base_ff [3], row_ff [3], base_in [3], row_in [3];
   logic [ssrast_pkg::COLOR_W-1:0] color_ff, color_in;
   logic [XW-1:0] start_x_ff, start_x_in, cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [XW:0]   end_x_ff, end_x_in, end_y_ff, end_y_in;
   logic          busy_ff, busy_in, setup1_ff, setup1_in, setup2_ff, setup2_in;

   // result register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [ssrast_pkg::PIX_W-1:0]   out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic [ssrast_pkg::MASK_W-1:0]  out_mask_ff, out_mask_in;
   logic [ssrast_pkg::COLOR_W-1:0] out_color_ff, out_color_in;
   logic          out_last_ff, out_last_in;

   logic req_fire, load_fire, step_fire;
   logic [1:0] side_log2, shift_amt;
   logic [ssrast_pkg::MASK_W-1:0] mask;
   logic signed [EW-1:0] offx [3][MAXS], offy [3][MAXS];

   // load-time box set-up
   logic signed [BW-1:0] mnx, mxx, mny, mxy, fw_s, fh_s;
   logic empty_box;

   assign req_tready = !(setup1_ff || setup2_ff) && (!rsp_valid_ff || rsp_tready);
   assign req_fire   = req_tvalid && req_tready;
   assign load_fire  = req_fire && (req_tuser == ssrast_pkg::OP_LOAD);
   assign step_fire  = req_fire && (req_tuser == ssrast_pkg::OP_STEP) && busy_ff;

   always_comb begin
      logic signed [CW-1:0] vx [3], vy [3];
      logic signed [CW-1:0] lox, hix, loy, hiy;
      logic [BW-1:0] fw_u, fh_u;
      for (int k = 0; k < 3; k++) begin
         vx[k] = req_tdata[(2*k)*CW +: CW];
         vy[k] = req_tdata[(2*k+1)*CW +: CW];
      end
      lox = vx[0]; hix = vx[0]; loy = vy[0]; hiy = vy[0];
      for (int k = 1; k < 3; k++) begin
         if (vx[k] < lox) lox = vx[k];
         if (vx[k] > hix) hix = vx[k];
         if (vy[k] < loy) loy = vy[k];
         if (vy[k] > hiy) hiy = vy[k];
      end
      mnx = BW'(lox) >>> COORD_FRAC_BITS;
      mny = BW'(loy) >>> COORD_FRAC_BITS;
      mxx = (BW'(hix) + BW'((1 << COORD_FRAC_BITS) - 1)) >>> COORD_FRAC_BITS;
      mxy = (BW'(hiy) + BW'((1 << COORD_FRAC_BITS) - 1)) >>> COORD_FRAC_BITS;
      fw_u = BW'(frame_w_ff);
      fh_u = BW'(frame_h_ff);
      if (fw_u > BW'(MAX_FRAME_SIDE)) fw_u = BW'(MAX_FRAME_SIDE);
      if (fh_u > BW'(MAX_FRAME_SIDE)) fh_u = BW'(MAX_FRAME_SIDE);
      fw_s = signed'(fw_u);
      fh_s = signed'(fh_u);
      if (mnx < 0) mnx = '0;
      if (mny < 0) mny = '0;
      if (mxx > fw_s) mxx = fw_s;
      if (mxy > fh_s) mxy = fh_s;
      empty_box = (mnx >= mxx) || (mny >= mxy);
      for (int k = 0; k < 3; k++) begin
         cx_in[k] = vx[k];
         cy_in[k] = vy[k];
         dx_in[k] = DW'(vx[(k+1)%3]) - DW'(vx[k]);
         dy_in[k] = DW'(vy[(k+1)%3]) - DW'(vy[k]);
      end
   end

   // per-sample offsets from the pixel's edge values
   assign side_log2 = (samples_log2_ff > 2'(MAXL)) ? 2'(MAXL) : samples_log2_ff;
   assign shift_amt = 2'(MAXL) - side_log2;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         for (int i = 0; i < MAXS; i++) begin
            offx[k][i] = ((EW'(dy_ff[k]) * EW'(2*i+1)) <<< shift_amt) <<< COORD_FRAC_BITS;
            offy[k][i] = ((EW'(dx_ff[k]) * EW'(2*i+1)) <<< shift_amt) <<< COORD_FRAC_BITS;
         end
      end
   end

   always_comb begin
      logic signed [EW-1:0] e;
      logic [2:0] pos, neg;
      logic [ssrast_pkg::MASK_IDX_W-1:0] idx;
      mask = '0;
      for (int j = 0; j < MAXS; j++) begin
         for (int i = 0; i < MAXS; i++) begin
            for (int k = 0; k < 3; k++) begin
               e = base_ff[k] + offx[k][i] - offy[k][j];
               neg[k] = e[EW-1];
               pos[k] = !e[EW-1] && (e != '0);
            end
            idx = ssrast_pkg::MASK_IDX_W'(i)
                  + ssrast_pkg::MASK_IDX_W'(ssrast_pkg::MASK_IDX_W'(j) << side_log2);
            if ((i < (1 << side_log2)) && (j < (1 << side_log2)) && ((&pos) || (&neg)))
               mask[idx] = 1'b1;
         end
      end
   end

   // next state
   always_comb begin
      logic signed [PW-1:0] ux, uy;
      logic x_wrap, y_done;
      color_in   = color_ff;
      start_x_in = start_x_ff;
      end_x_in   = end_x_ff;
      end_y_in   = end_y_ff;
      cur_x_in   = cur_x_ff;
      cur_y_in   = cur_y_ff;
      busy_in    = busy_ff;
      setup1_in  = 1'b0;
      setup2_in  = setup1_ff;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_mask_in  = out_mask_ff;
      out_color_in = out_color_ff;
      out_last_in  = out_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      ux = signed'(PW'(start_x_ff) << COORD_FRAC_BITS);
      uy = signed'(PW'(cur_y_ff) << COORD_FRAC_BITS);
      x_wrap = ((XW+1)'(cur_x_ff) + 1'b1) >= end_x_ff;
      y_done = ((XW+1)'(cur_y_ff) + 1'b1) >= end_y_ff;
      for (int k = 0; k < 3; k++) begin
         prx_in[k]  = MW'(dy_ff[k]) * MW'(ux - PW'(cx_ff[k]));
         pry_in[k]  = MW'(dx_ff[k]) * MW'(uy - PW'(cy_ff[k]));
         base_in[k] = base_ff[k];
         row_in[k]  = row_ff[k];
      end

      if (setup2_ff) begin
         for (int k = 0; k < 3; k++) begin
            base_in[k] = (EW'(prx_ff[k]) - EW'(pry_ff[k])) <<< LK;
            row_in[k]  = (EW'(prx_ff[k]) - EW'(pry_ff[k])) <<< LK;
         end
         busy_in = 1'b1;
      end

      if (load_fire) begin
         color_in   = req_tdata[6*CW +: ssrast_pkg::COLOR_W];
         start_x_in = mnx[XW-1:0];
         cur_x_in   = mnx[XW-1:0];
         cur_y_in   = mny[XW-1:0];
         end_x_in   = mxx[XW:0];
         end_y_in   = mxy[XW:0];
         busy_in    = 1'b0;
         setup1_in  = !empty_box;
      end

      if (step_fire) begin
         rsp_valid_in = 1'b1;
         out_x_in     = ssrast_pkg::PIX_W'(cur_x_ff);
         out_y_in     = ssrast_pkg::PIX_W'(cur_y_ff);
         out_mask_in  = mask;
         out_color_in = color_ff;
         out_last_in  = x_wrap && y_done;
         if (x_wrap) begin
            cur_x_in = start_x_ff;
            if (y_done) begin
               busy_in = 1'b0;
            end else begin
               cur_y_in = cur_y_ff + 1'b1;
               for (int k = 0; k < 3; k++) begin
                  row_in[k]  = row_ff[k] - (EW'(dx_ff[k]) <<< (COORD_FRAC_BITS + LK));
                  base_in[k] = row_in[k];
               end
            end
         end else begin
            cur_x_in = cur_x_ff + 1'b1;
            for (int k = 0; k < 3; k++)
               base_in[k] = base_ff[k] + (EW'(dy_ff[k]) <<< (COORD_FRAC_BITS + LK));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         setup1_ff    <= 1'b0;
         setup2_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         setup1_ff    <= setup1_in;
         setup2_ff    <= setup2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_fire) begin
         for (int k = 0; k < 3; k++) begin
            cx_ff[k] <= cx_in[k];
            cy_ff[k] <= cy_in[k];
            dx_ff[k] <= dx_in[k];
            dy_ff[k] <= dy_in[k];
         end
      end
      for (int k = 0; k < 3; k++) begin
         prx_ff[k]  <= prx_in[k];
         pry_ff[k]  <= pry_in[k];
         base_ff[k] <= base_in[k];
         row_ff[k]  <= row_in[k];
      end
      color_ff     <= color_in;
      start_x_ff   <= start_x_in;
      end_x_ff     <= end_x_in;
      end_y_ff     <= end_y_in;
      cur_x_ff     <= cur_x_in;
      cur_y_ff     <= cur_y_in;
      out_x_ff     <= out_x_in;
      out_y_ff     <= out_y_in;
      out_mask_ff  <= out_mask_in;
      out_color_ff <= out_color_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {2'b00, out_color_ff, out_mask_ff, out_y_ff, out_x_ff};

   `SSRAST_ASSERT_IMPLY(a_setup_stalls, clock, reset, setup1_ff || setup2_ff, !req_tready, "item taken during edge set-up")
   `SSRAST_ASSERT_NEXT(a_setup_arms, clock, reset, setup2_ff, busy_ff, "traversal not started after set-up")
   `SSRAST_ASSERT_IMPLY(a_cursor_in_box, clock, reset, busy_ff, ((XW+1)'(cur_x_ff) < end_x_ff) && ((XW+1)'(cur_y_ff) < end_y_ff), "cursor outside box")

endmodule
